// ----- sv/opek_pkg.sv -----
// Shared types and constants of the order-preserving key encoder.
package opek_pkg;

    // Item kinds carried in the opcode field.
    localparam logic [2:0] OP_INT64     = 3'd0;
    localparam logic [2:0] OP_FLOAT64   = 3'd1;
    localparam logic [2:0] OP_BOOL      = 3'd2;
    localparam logic [2:0] OP_STR_START = 3'd3;
    localparam logic [2:0] OP_STR_BYTE  = 3'd4;
    localparam logic [2:0] OP_STR_END   = 3'd5;

    // Configuration register indexes.
    localparam logic [1:0] REG_TAG_STRING  = 2'd0;
    localparam logic [1:0] REG_TAG_INT64   = 2'd1;
    localparam logic [1:0] REG_TAG_FLOAT64 = 2'd2;
    localparam logic [1:0] REG_TAG_BOOL    = 2'd3;

    // Tag reset values.
    localparam logic [7:0] RST_TAG_STRING  = 8'd3;
    localparam logic [7:0] RST_TAG_INT64   = 8'd1;
    localparam logic [7:0] RST_TAG_FLOAT64 = 8'd2;
    localparam logic [7:0] RST_TAG_BOOL    = 8'd4;

    localparam logic [63:0] SIGN_BIT = 64'h8000_0000_0000_0000;
    localparam logic [7:0]  BYTE_ESC = 8'hFF;

    // A job holds up to nine bytes, oldest in the top byte.
    localparam int JOB_BYTES = 9;
    localparam int JOB_W     = 8 * JOB_BYTES;
    localparam int CNT_W     = $clog2(JOB_BYTES + 1);

    typedef struct packed {
        logic [2:0]  opcode;
        logic [63:0] payload;
    } t_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_byte;
        logic       error;
    } t_result;

    typedef struct packed {
        logic [7:0] tag_string;
        logic [7:0] tag_int64;
        logic [7:0] tag_float64;
        logic [7:0] tag_bool;
    } t_tags;

    typedef struct packed {
        logic [JOB_W-1:0] bytes;
        logic [CNT_W-1:0] count;
        logic             err;
    } t_job;

    // Handshake between the job queue and the serializer.
    typedef struct packed {
        logic empty;
        logic pop;
    } t_qlink;

endpackage

// ----- sv/order_preserving_key_encoder.sv -----
// Top level of the order-preserving key encoder: config registers and datapath wiring.
//
// Converts typed values (int64, float64, bool, string start/byte/end) into byte
// strings whose unsigned lexicographic order matches value order. Push one item
// per transfer on the input queue side; pop one byte per transfer on the result
// side, with last_byte marking the final byte of each item. An int64 or a finite
// float64 takes 9 result transfers, a bool or string end 2, a string start 1, a
// string byte 1 (2 for a zero byte), and an error item 1. Throughput is set by
// the result port, which moves one byte per cycle while pop is held, so single-byte
// items go at one per cycle. The front end classifies each item into a job in the
// same cycle it is pushed; a two-entry job queue sits between it and the
// serializer, so push stays open while bytes of earlier items are still going
// out. Tags are sampled when the item is pushed. The four tag registers sit at
// byte addresses 0, 4, 8 and 12 of the APB port; only the low 8 bits of a
// write are kept, and a read returns the tag zero extended.
module order_preserving_key_encoder (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // input queue side
    input  logic                push,
    output logic                full,
    input  opek_pkg::t_item     i_item,
    // result queue side
    output logic                empty,
    input  logic                pop,
    output opek_pkg::t_result   o_result,
    // configuration port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    opek_pkg::t_tags  r_tags;
    opek_pkg::t_job   w_front_job;
    opek_pkg::t_job   w_q_job;
    opek_pkg::t_qlink w_link;
    logic             w_q_empty;
    logic             w_cfg_wr;
    logic [1:0]       w_reg_idx;

    // Config port: no wait states.
    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite && pready;
    assign w_reg_idx = paddr[3:2];

    // Tag registers; keep the low byte of each write.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tags.tag_string  <= opek_pkg::RST_TAG_STRING;
            r_tags.tag_int64   <= opek_pkg::RST_TAG_INT64;
            r_tags.tag_float64 <= opek_pkg::RST_TAG_FLOAT64;
            r_tags.tag_bool    <= opek_pkg::RST_TAG_BOOL;
        end else if (w_cfg_wr) begin
            unique case (w_reg_idx)
                opek_pkg::REG_TAG_STRING:  r_tags.tag_string  <= pwdata[7:0];
                opek_pkg::REG_TAG_INT64:   r_tags.tag_int64   <= pwdata[7:0];
                opek_pkg::REG_TAG_FLOAT64: r_tags.tag_float64 <= pwdata[7:0];
                opek_pkg::REG_TAG_BOOL:    r_tags.tag_bool    <= pwdata[7:0];
                default:                   r_tags             <= r_tags;
            endcase
        end
    end

    // Read back the addressed tag.
    always_comb begin
        prdata = 32'd0;
        unique case (w_reg_idx)
            opek_pkg::REG_TAG_STRING:  prdata = {24'd0, r_tags.tag_string};
            opek_pkg::REG_TAG_INT64:   prdata = {24'd0, r_tags.tag_int64};
            opek_pkg::REG_TAG_FLOAT64: prdata = {24'd0, r_tags.tag_float64};
            opek_pkg::REG_TAG_BOOL:    prdata = {24'd0, r_tags.tag_bool};
            default:                   prdata = 32'd0;
        endcase
    end

    // Classify the incoming item into a byte job.
    opek_front u_front (
        .i_item (i_item),
        .i_tags (r_tags),
        .o_job  (w_front_job)
    );

    // Hold up to two jobs while the serializer drains earlier ones.
    opek_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (w_front_job),
        .o_full  (full),
        .i_pop   (w_link.pop),
        .o_empty (w_q_empty),
        .o_job   (w_q_job)
    );

    // Send the bytes of each job, one result transfer per byte.
    opek_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_job      (w_q_job),
        .o_link_pop (w_link),
        .i_q_empty  (w_q_empty),
        .o_empty    (empty),
        .i_pop      (pop),
        .o_result   (o_result)
    );

    a_pop_needs_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_link.pop |-> !w_link.empty) else $error("job pulled from empty queue");

    a_reset_tags: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_tags.tag_string == opek_pkg::RST_TAG_STRING
                      && r_tags.tag_bool == opek_pkg::RST_TAG_BOOL))
        else $error("tags not reset");

    a_refill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (empty && !w_q_empty) |=> !empty) else $error("serializer did not load job");

endmodule

// ----- sv/opek_front.sv -----
// Front end: classify an input item into a byte job.
module opek_front (
    input  opek_pkg::t_item i_item,
    input  opek_pkg::t_tags i_tags,
    output opek_pkg::t_job  o_job
);

    logic [63:0] w_flt;
    logic        w_nonfinite;
    logic [7:0]  w_sbyte;

    assign w_nonfinite = &i_item.payload[62:52];
    assign w_flt       = i_item.payload[63] ? ~i_item.payload
                                            : (i_item.payload ^ opek_pkg::SIGN_BIT);
    assign w_sbyte     = i_item.payload[7:0];

    always_comb begin
        o_job = '0;
        unique case (i_item.opcode)
            opek_pkg::OP_INT64: begin
                o_job.bytes = {i_tags.tag_int64, i_item.payload ^ opek_pkg::SIGN_BIT};
                o_job.count = opek_pkg::CNT_W'(9);
            end
            opek_pkg::OP_FLOAT64: begin
                if (w_nonfinite) begin
                    o_job.count = opek_pkg::CNT_W'(1);
                    o_job.err   = 1'b1;
                end else begin
                    o_job.bytes = {i_tags.tag_float64, w_flt};
                    o_job.count = opek_pkg::CNT_W'(9);
                end
            end
            opek_pkg::OP_BOOL: begin
                o_job.bytes = {i_tags.tag_bool, 7'd0, (i_item.payload != 64'd0), 56'd0};
                o_job.count = opek_pkg::CNT_W'(2);
            end
            opek_pkg::OP_STR_START: begin
                o_job.bytes = {i_tags.tag_string, 64'd0};
                o_job.count = opek_pkg::CNT_W'(1);
            end
            opek_pkg::OP_STR_BYTE: begin
                if (w_sbyte == 8'd0) begin
                    // escape a zero byte as 00 FF
                    o_job.bytes = {8'd0, opek_pkg::BYTE_ESC, 56'd0};
                    o_job.count = opek_pkg::CNT_W'(2);
                end else begin
                    o_job.bytes = {w_sbyte, 64'd0};
                    o_job.count = opek_pkg::CNT_W'(1);
                end
            end
            opek_pkg::OP_STR_END: begin
                o_job.count = opek_pkg::CNT_W'(2);
            end
            default: begin
                o_job.count = opek_pkg::CNT_W'(1);
                o_job.err   = 1'b1;
            end
        endcase
    end

endmodule

// ----- sv/opek_queue.sv -----
// Two-entry job queue between front end and serializer.
module opek_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  opek_pkg::t_job    i_job,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_empty,
    output opek_pkg::t_job    o_job
);

    opek_pkg::t_job r_mem [2];
    logic           r_wr;
    logic           r_rd;
    logic [1:0]     r_cnt;
    logic [1:0]     n_cnt;
    logic           w_do_push;
    logic           w_do_pop;

    assign o_full    = (r_cnt == 2'd2);
    assign o_empty   = (r_cnt == 2'd0);
    assign o_job     = r_mem[r_rd];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;

    always_comb begin
        n_cnt = r_cnt;
        case ({w_do_push, w_do_pop})
            2'b10:   n_cnt = r_cnt + 2'd1;
            2'b01:   n_cnt = r_cnt - 2'd1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (w_do_push) begin
                r_wr <= ~r_wr;
            end
            if (w_do_pop) begin
                r_rd <= ~r_rd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("queue count out of range");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0 || r_cnt == 2'd2) |-> (r_wr == r_rd)) else $error("pointer mismatch");

    a_ptr_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd1) |-> (r_wr != r_rd)) else $error("pointer mismatch at one entry");

endmodule

// ----- sv/opek_back.sv -----
// Back end: serialize one job into result bytes.
module opek_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  opek_pkg::t_job      i_job,
    output opek_pkg::t_qlink    o_link_pop,
    input  logic                i_q_empty,
    output logic                o_empty,
    input  logic                i_pop,
    output opek_pkg::t_result   o_result
);

    logic                           r_busy;
    logic [opek_pkg::JOB_W-1:0]     r_bytes;
    logic [opek_pkg::CNT_W-1:0]     r_cnt;
    logic                           r_err;
    logic                           w_take;
    logic                           w_last;
    logic                           w_free;

    assign w_last = (r_cnt == opek_pkg::CNT_W'(1));
    assign w_take = i_pop && r_busy;
    // the holding register frees up when idle or when its final byte goes out
    assign w_free = !r_busy || (w_take && w_last);

    assign o_link_pop.empty = i_q_empty;
    assign o_link_pop.pop   = w_free && !i_q_empty;

    assign o_empty            = !r_busy;
    assign o_result.out_byte  = r_bytes[opek_pkg::JOB_W-1 -: 8];
    assign o_result.last_byte = w_last;
    assign o_result.error     = r_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (w_free) begin
            r_busy <= !i_q_empty;
            r_cnt  <= i_job.count;
        end else if (w_take) begin
            r_cnt <= r_cnt - opek_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_free) begin
            r_bytes <= i_job.bytes;
            r_err   <= i_job.err;
        end else if (w_take) begin
            r_bytes <= {r_bytes[opek_pkg::JOB_W-9:0], 8'd0};
        end
    end

    a_cnt_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_cnt != '0 && r_cnt <= opek_pkg::CNT_W'(opek_pkg::JOB_BYTES)))
        else $error("byte count out of range");

    a_err_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_err) |-> w_last) else $error("error result not single");

    a_cnt_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && !w_last) |=> (r_busy && r_cnt == $past(r_cnt) - opek_pkg::CNT_W'(1)))
        else $error("byte count did not advance");

endmodule
